// ===== rtl/core/pprp_pkg.sv =====
// Shared types, codes and byte-step functions for the pixel POST request parser.
package pprp_pkg;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_POST  = 3'd1,
    ST_EXIT      = 3'd2,
    ST_DUPLICATE = 3'd3,
    ST_INCOMPLETE = 3'd4
  } status_t;

  // Number parse phases
  typedef enum logic [1:0] {
    PH_SPACE  = 2'd0,
    PH_DIGITS = 2'd1,
    PH_DONE   = 2'd2
  } num_phase_t;

  localparam int unsigned NumFields = 5;
  localparam logic [2:0] HeadLen  = 3'd4;
  localparam logic [3:0] ExitLen  = 4'd11;
  localparam logic [3:0] ExitFail = 4'd15;
  localparam logic [4:0] AllNames = 5'h1f;

  localparam logic [7:0] ChNewline = 8'h0a;
  localparam logic [7:0] ChAmp     = 8'h26;
  localparam logic [7:0] ChEquals  = 8'h3d;
  localparam logic [7:0] ChPlus    = 8'h2b;
  localparam logic [7:0] ChMinus   = 8'h2d;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;
  localparam logic [7:0] ChSpace   = 8'h20;

  // Parser state, one update per byte
  typedef struct packed {
    logic [2:0]                 header_position;
    logic                       header_bad;
    logic                       content_ended;
    logic                       line_closed;
    logic [3:0]                 exit_match_position;
    logic                       exit_seen;
    logic [1:0]                 token_position;
    logic [7:0]                 token_name;
    logic                       equals_seen;
    num_phase_t                 number_phase;
    logic                       number_negative;
    logic [7:0]                 number_value;
    logic [4:0]                 names_seen;
    logic                       duplicate_seen;
    logic [NumFields-1:0][7:0]  field_values;
  } parse_state_t;

  // One parsed request
  typedef struct packed {
    status_t    status;
    logic [7:0] pixel_x;
    logic [7:0] pixel_y;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } result_t;

  function automatic logic [7:0] head_char(logic [1:0] pos);
    logic [7:0] ch;
    case (pos)
      2'd0:    ch = 8'h50;  // P
      2'd1:    ch = 8'h4f;  // O
      2'd2:    ch = 8'h53;  // S
      default: ch = 8'h54;  // T
    endcase
    return ch;
  endfunction

  // "action=exit"
  function automatic logic [7:0] exit_char(logic [3:0] pos);
    logic [7:0] ch;
    case (pos)
      4'd0:    ch = 8'h61;
      4'd1:    ch = 8'h63;
      4'd2:    ch = 8'h74;
      4'd3:    ch = 8'h69;
      4'd4:    ch = 8'h6f;
      4'd5:    ch = 8'h6e;
      4'd6:    ch = 8'h3d;
      4'd7:    ch = 8'h65;
      4'd8:    ch = 8'h78;
      4'd9:    ch = 8'h69;
      4'd10:   ch = 8'h74;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic name_known(logic [7:0] c);
    return (c == 8'h78) || (c == 8'h79) || (c == 8'h72) || (c == 8'h67) || (c == 8'h62);
  endfunction

  // Slot order x, y, r, g, b
  function automatic logic [2:0] name_slot(logic [7:0] c);
    logic [2:0] slot;
    case (c)
      8'h78:   slot = 3'd0;
      8'h79:   slot = 3'd1;
      8'h72:   slot = 3'd2;
      8'h67:   slot = 3'd3;
      default: slot = 3'd4;
    endcase
    return slot;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == ChSpace) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic parse_state_t reset_state();
    parse_state_t s;
    s = '0;
    s.number_phase = PH_SPACE;
    s.line_closed  = 1'b1;
    return s;
  endfunction

  function automatic parse_state_t number_clear(parse_state_t s_in);
    parse_state_t s;
    s = s_in;
    s.number_phase    = PH_SPACE;
    s.number_negative = 1'b0;
    s.number_value    = 8'd0;
    return s;
  endfunction

  function automatic parse_state_t number_feed(parse_state_t s_in, logic [7:0] c);
    parse_state_t s;
    logic         digit;
    logic [7:0]   acc;
    s     = s_in;
    digit = (c >= ChZero) && (c <= ChNine);
    acc   = 8'(s.number_value * 8'd10 + 8'(c - ChZero));
    case (s.number_phase)
      PH_SPACE: begin
        if (!is_space(c)) begin
          if ((c == ChPlus) || (c == ChMinus)) begin
            s.number_negative = (c == ChMinus);
            s.number_phase    = PH_DIGITS;
          end else if (digit) begin
            s.number_value = acc;
            s.number_phase = PH_DIGITS;
          end else begin
            s.number_phase = PH_DONE;
          end
        end
      end
      PH_DIGITS: begin
        if (digit) s.number_value = acc;
        else s.number_phase = PH_DONE;
      end
      default: ;
    endcase
    return s;
  endfunction

  // Close the open token and store its value if it names a field not yet seen, else flag a duplicate
  function automatic parse_state_t token_commit(parse_state_t s_in);
    parse_state_t s;
    logic [2:0]   slot;
    logic [7:0]   v;
    s    = s_in;
    slot = name_slot(s.token_name);
    v    = s.number_negative ? 8'(8'd0 - s.number_value) : s.number_value;
    if ((s.token_position != 2'd0) && name_known(s.token_name)) begin
      if (s.names_seen[slot]) begin
        s.duplicate_seen = 1'b1;
      end else begin
        s.field_values[slot] = v;
        s.names_seen[slot]   = 1'b1;
      end
    end
    s.token_position = 2'd0;
    s.token_name     = 8'd0;
    s.equals_seen    = 1'b0;
    return number_clear(s);
  endfunction

  function automatic parse_state_t line_clear(parse_state_t s_in);
    parse_state_t s;
    s = s_in;
    s.exit_match_position = 4'd0;
    s.exit_seen           = 1'b0;
    s.token_position      = 2'd0;
    s.token_name          = 8'd0;
    s.equals_seen         = 1'b0;
    s.names_seen          = 5'd0;
    s.duplicate_seen      = 1'b0;
    s.field_values        = '0;
    return number_clear(s);
  endfunction

  // Apply one non-zero content byte
  function automatic parse_state_t content_byte(parse_state_t s_in, logic [7:0] c);
    parse_state_t s;
    s = s_in;
    if (c == ChNewline) begin
      s = token_commit(s);
      s.line_closed = 1'b1;
    end else begin
      if (s.line_closed) begin
        s = line_clear(s);
        s.line_closed = 1'b0;
      end
      if (s.exit_match_position < ExitLen) begin
        if (c == exit_char(s.exit_match_position)) begin
          s.exit_match_position = s.exit_match_position + 4'd1;
          if (s.exit_match_position == ExitLen) s.exit_seen = 1'b1;
        end else begin
          s.exit_match_position = ExitFail;
        end
      end
      if (c == ChAmp) begin
        s = token_commit(s);
      end else if (s.token_position == 2'd0) begin
        s.token_name     = c;
        s.equals_seen    = (c == ChEquals);
        s                = number_clear(s);
        s.token_position = 2'd1;
      end else begin
        if (!s.equals_seen && (c == ChEquals)) begin
          s.equals_seen = 1'b1;
          s             = number_clear(s);
        end else begin
          s = number_feed(s, c);
        end
        s.token_position = 2'd2;
      end
    end
    return s;
  endfunction

endpackage

// ===== rtl/core/pprp_parse_core.sv =====
// Per-byte parser state and result decision for the pixel POST request parser.
module pprp_parse_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        data_byte,
  input  logic              is_last,
  output logic              res_valid,
  output pprp_pkg::result_t res
);
  import pprp_pkg::*;

  parse_state_t st;
  parse_state_t st_next;
  parse_state_t work;

  // Advance the state by one byte and close the request on the last byte
  always_comb begin
    work = st;
    if (work.header_position < HeadLen) begin
      if (data_byte != head_char(work.header_position[1:0])) work.header_bad = 1'b1;
      work.header_position = work.header_position + 3'd1;
    end
    if (!work.content_ended) begin
      if (data_byte == 8'd0) work.content_ended = 1'b1;
      else work = content_byte(work, data_byte);
    end
    if (is_last) work = token_commit(work);
    st_next = is_last ? reset_state() : work;
  end

  // Pick the status by priority and zero the values unless ok
  always_comb begin
    res = '0;
    if (work.header_bad || (work.header_position < HeadLen)) res.status = ST_NOT_POST;
    else if (work.exit_seen) res.status = ST_EXIT;
    else if (work.duplicate_seen) res.status = ST_DUPLICATE;
    else if (work.names_seen == AllNames) res.status = ST_OK;
    else res.status = ST_INCOMPLETE;
    if (res.status == ST_OK) begin
      res.pixel_x = work.field_values[0];
      res.pixel_y = work.field_values[1];
      res.red     = work.field_values[2];
      res.green   = work.field_values[3];
      res.blue    = work.field_values[4];
    end
  end

  assign res_valid = step && is_last;

  // Hold state between bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= reset_state();
    end else if (step) begin
      st <= st_next;
    end
  end

  a_clear_after_result: assert property (@(posedge clk) disable iff (rst)
    step && is_last |=> st == reset_state())
    else $error("parser state not cleared after a result");

  a_header_bounded: assert property (@(posedge clk) disable iff (rst)
    st.header_position <= HeadLen)
    else $error("header position ran past the header");

  a_exit_consistent: assert property (@(posedge clk) disable iff (rst)
    st.exit_seen |-> st.exit_match_position == ExitLen)
    else $error("exit flag set without a full match");

endmodule

// ===== rtl/core/pixel_post_request_parser_unit.sv =====
// Top level of the pixel POST request parser: input register, parser, result register.
// A last byte accepted into the input register is parsed by the core, and its result is
//   registered in the result register and shown on m_tvalid/m_tdata.
// Throughput: one byte per cycle; a last byte waits in the input register only while an
//   earlier result is held on the output.
// Reset: rst is synchronous, active high; it empties both registers and returns the
//   parser to the start of a request.
module pixel_post_request_parser_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // is_last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // [2:0] status, [10:3] pixel_x, [18:11] pixel_y,
                                 // [26:19] red, [34:27] green, [42:35] blue, [47:43] zero
);
  import pprp_pkg::*;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       step;
  logic       res_valid;
  result_t    res;
  result_t    out_res;

  // Parse the held byte unless it closes a request whose result has no room
  assign step     = in_valid && (!in_last || !m_tvalid || m_tready);
  assign s_tready = !in_valid || step;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  pprp_parse_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .data_byte (in_byte),
    .is_last   (in_last),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register: drop on transfer, load on a new result
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) out_res <= res;
  end

  assign m_tdata = {5'd0, out_res.blue, out_res.green, out_res.red,
                    out_res.pixel_y, out_res.pixel_x, out_res.status};

  a_result_follows_last: assert property (@(posedge clk) disable iff (rst)
    step && in_last |=> m_tvalid)
    else $error("last byte parsed but no result shown");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_valid && in_last && m_tvalid && !m_tready)
    else $error("input stalled without a blocked result");

  a_values_zero_on_error: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (out_res.status != ST_OK) |-> m_tdata[42:3] == 40'd0)
    else $error("values present on an error result");

endmodule
